### rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants and the stage record for the nearest palette color search.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CMP_W  = (IDX_W > 8) ? IDX_W : 8;
  localparam int CH_W   = 8;
  localparam int SQ_W   = 2 * CH_W;
  localparam int DIST_W = SQ_W + 2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [7:0]        entry_index;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
    logic              cand_valid;
    logic [DIST_W-1:0] cand_dist;
    logic [IDX_W-1:0]  cand_idx;
  } stage_t;

endpackage

`default_nettype wire

### rtl/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell
// One palette entry: takes writes aimed at it, computes its distance to a
// passing query and folds the previous cell's distance into the running best.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     advance,
  input  wire logic [npcs_pkg::IDX_W-1:0] cell_index,
  input  wire npcs_pkg::stage_t         stage_in,
  output npcs_pkg::stage_t              stage_out
);

  logic [npcs_pkg::CH_W-1:0] red_r, green_r, blue_r;
  npcs_pkg::stage_t          stage_r, stage_nxt;

  logic                        write_hit;
  logic                        take;
  logic [npcs_pkg::CH_W-1:0]   dr, dg, db;
  logic [npcs_pkg::SQ_W-1:0]   sr, sg, sb;
  logic [npcs_pkg::DIST_W-1:0] sq_sum;

  function automatic logic [npcs_pkg::CH_W-1:0] absdiff(
    input logic [npcs_pkg::CH_W-1:0] a,
    input logic [npcs_pkg::CH_W-1:0] b
  );
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    write_hit = stage_in.valid && (stage_in.mode == npcs_pkg::MODE_WRITE) &&
                (npcs_pkg::CMP_W'(stage_in.entry_index) ==
                 npcs_pkg::CMP_W'(cell_index));
    take = stage_in.cand_valid && (stage_in.cand_dist < stage_in.best_dist);

    dr = absdiff(stage_in.red, red_r);
    dg = absdiff(stage_in.green, green_r);
    db = absdiff(stage_in.blue, blue_r);
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    sq_sum = npcs_pkg::DIST_W'(sr) + npcs_pkg::DIST_W'(sg) + npcs_pkg::DIST_W'(sb);

    stage_nxt            = stage_in;
    stage_nxt.best_dist  = take ? stage_in.cand_dist : stage_in.best_dist;
    stage_nxt.best_idx   = take ? stage_in.cand_idx : stage_in.best_idx;
    stage_nxt.cand_valid = 1'b1;
    stage_nxt.cand_dist  = sq_sum;
    stage_nxt.cand_idx   = cell_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r         <= '0;
      green_r       <= '0;
      blue_r        <= '0;
      stage_r.valid <= 1'b0;
    end else if (advance) begin
      stage_r <= stage_nxt;
      if (write_hit) begin
        red_r   <= stage_in.red;
        green_r <= stage_in.green;
        blue_r  <= stage_in.blue;
      end
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

### rtl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette of RGB entries held in a chain of cells; queries return the index
// of the closest entry by squared RGB distance, lowest index on ties.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  input   | in_valid in_ready in_mode in_entry_index     | in
//          | in_red in_green in_blue                      |
//  result  | out_valid out_ready out_best_index           | out
//
//  One transaction enters per cycle while the chain is not held; each walks
//  one cell per cycle likewise, and a query leaves via the output register.
//  Writes travel the same chain and update their cell in order; they give no
//  result. Reset clears the palette to black at once.
//  The whole chain holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_entry_index,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_best_index
);

  localparam int N = npcs_pkg::PALETTE_ENTRIES;

  npcs_pkg::stage_t chain [0:N];

  logic                         advance;
  logic                         take;
  logic [npcs_pkg::IDX_W-1:0]   final_idx;
  logic [npcs_pkg::CMP_W-1:0]   final_wide;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_best_r, out_best_nxt;

  assign advance = !out_valid_r || out_ready;
  assign in_ready = advance;

  always_comb begin
    chain[0]             = '0;
    chain[0].valid       = in_valid;
    chain[0].mode        = in_mode;
    chain[0].entry_index = in_entry_index;
    chain[0].red         = in_red;
    chain[0].green       = in_green;
    chain[0].blue        = in_blue;
    chain[0].best_dist   = npcs_pkg::DIST_MAX;
    chain[0].best_idx    = '0;
    chain[0].cand_valid  = 1'b0;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    npcs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .cell_index (npcs_pkg::IDX_W'(k)),
      .stage_in   (chain[k]),
      .stage_out  (chain[k+1])
    );
  end

  always_comb begin
    take = chain[N].cand_valid && (chain[N].cand_dist < chain[N].best_dist);
    final_idx = take ? chain[N].cand_idx : chain[N].best_idx;
    final_wide = npcs_pkg::CMP_W'(final_idx);
    out_best_nxt = final_wide[7:0];
    out_valid_nxt = chain[N].valid && (chain[N].mode == npcs_pkg::MODE_QUERY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
      out_best_r  <= out_best_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_best_r;

  a_query_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance && chain[N].valid && (chain[N].mode == npcs_pkg::MODE_QUERY)
    |=> out_valid)
    else $error("query at chain end did not reach output");

  a_chain_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(chain[N]))
    else $error("chain moved while output stalled");

  a_final_has_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    chain[N].valid |-> chain[N].cand_valid)
    else $error("chain end holds no candidate distance");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for nearest_palette_color_search. The bench keeps its own copy of
// the palette and works out the nearest entry for every accepted query.
// Results are compared in order. Directed tests cover the black palette after
// reset, the channel extremes and tie breaking. Further tests cover
// back-to-back traffic, a long output stall and mixed random writes and
// queries.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int HOLD_CYCLES = 700;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_mode = npcs_pkg::MODE_WRITE;
  logic [7:0] in_entry_index = 8'd0;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_best_index;

  logic [7:0] pal_r [npcs_pkg::PALETTE_ENTRIES];
  logic [7:0] pal_g [npcs_pkg::PALETTE_ENTRIES];
  logic [7:0] pal_b [npcs_pkg::PALETTE_ENTRIES];
  logic [7:0] pending_best [$];

  logic idle_enable = 1'b1;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   error_count = 0;
  int   cycles = 0;

  nearest_palette_color_search uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_index (out_best_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int best_dist;
    int sum_sq;
    int dr;
    int dg;
    int db;
    logic [7:0] best;
    best_dist = 32'h7fffffff;
    best = 8'd0;
    for (int i = 0; i < npcs_pkg::PALETTE_ENTRIES; i++) begin
      dr = int'(pal_r[i]) - int'(r);
      dg = int'(pal_g[i]) - int'(g);
      db = int'(pal_b[i]) - int'(b);
      sum_sq = dr * dr + dg * dg + db * db;
      if (sum_sq < best_dist) begin
        best_dist = sum_sq;
        best = 8'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    while (idle_enable && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mode == npcs_pkg::MODE_WRITE) begin
      if (int'(idx) < npcs_pkg::PALETTE_ENTRIES) begin
        pal_r[idx] = r;
        pal_g[idx] = g;
        pal_b[idx] = b;
      end
    end else begin
      pending_best.push_back(nearest_entry(r, g, b));
    end
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
    send_item(npcs_pkg::MODE_WRITE, idx, r, g, b);
  endtask

  task automatic query(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(npcs_pkg::MODE_QUERY, 8'($urandom), r, g, b);
  endtask

  task automatic query_near_entry();
    int k;
    k = $urandom_range(npcs_pkg::PALETTE_ENTRIES - 1);
    query(nudge(pal_r[k]), nudge(pal_g[k]), nudge(pal_b[k]));
  endtask

  task automatic test_black_palette();
    query(8'd0, 8'd0, 8'd0);
    query(8'd255, 8'd255, 8'd255);
    query(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_extremes();
    write_entry(8'd255, 8'd255, 8'd255, 8'd255);
    query(8'd255, 8'd255, 8'd255);
    query(8'd0, 8'd0, 8'd0);
    write_entry(8'd0, 8'd255, 8'd0, 8'd0);
    write_entry(8'd128, 8'd0, 8'd255, 8'd0);
    write_entry(8'd1, 8'd0, 8'd0, 8'd255);
    query(8'd255, 8'd0, 8'd0);
    query(8'd0, 8'd255, 8'd0);
    query(8'd0, 8'd0, 8'd255);
    query(8'd0, 8'd0, 8'd0);
    query(8'd200, 8'd200, 8'd200);
  endtask

  task automatic test_tie_break();
    write_entry(8'd40, 8'd77, 8'd33, 8'd150);
    write_entry(8'd41, 8'd77, 8'd33, 8'd150);
    query(8'd77, 8'd33, 8'd150);
    write_entry(8'd50, 8'd100, 8'd180, 8'd100);
    write_entry(8'd60, 8'd102, 8'd180, 8'd100);
    query(8'd101, 8'd180, 8'd100);
    // query on the same entry right behind the write that changes it
    write_entry(8'd41, 8'd10, 8'd240, 8'd10);
    query(8'd10, 8'd240, 8'd10);
    query(8'd77, 8'd33, 8'd150);
  endtask

  task automatic test_back_to_back();
    idle_enable <= 1'b0;
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(3) == 0)
        write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        query_near_entry();
    end
    idle_enable <= 1'b1;
  endtask

  task automatic test_output_stall();
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(4) == 0)
        write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else if ($urandom_range(1) == 0)
        query_near_entry();
      else
        query(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_mix();
    int k;
    for (int i = 0; i < 330; i++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        3: begin
          // duplicate color to provoke ties
          k = $urandom_range(npcs_pkg::PALETTE_ENTRIES - 1);
          write_entry(8'($urandom), pal_r[k], pal_g[k], pal_b[k]);
        end
        4, 5, 6: query_near_entry();
        default: query(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (idle_enable) begin
      out_ready <= ($urandom_range(99) >= 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_best.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual best_index %0d",
                 $time, out_best_index);
      end else begin
        if (out_best_index !== pending_best[0]) begin
          error_count++;
          $display("%0t: best_index mismatch, expected %0d, actual %0d",
                   $time, pending_best[0], out_best_index);
        end
        void'(pending_best.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < npcs_pkg::PALETTE_ENTRIES; i++) begin
      pal_r[i] = 8'd0;
      pal_g[i] = 8'd0;
      pal_b[i] = 8'd0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_black_palette();
    test_extremes();
    test_tie_break();
    test_back_to_back();
    test_output_stall();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk);
    repeat (npcs_pkg::PALETTE_ENTRIES + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
